>>> rtl/core/lohash_pkg.sv
// Shared types and constants of the legacy object hash block.
// Used by rtl/core modules but the fifo; depends on nothing.
package lohash_pkg;

    localparam int WORD_BITS_DEF  = 64;
    localparam int DIGIT_BITS_DEF = 30;
    localparam int ELEM_W         = 30;
    localparam int OUT_W          = 64;
    localparam int MULT_W         = 20;
    localparam logic [MULT_W-1:0] MULTIPLIER = 20'd1000003;
    localparam int SEED_SHIFT     = 7;
    localparam int MID_DEPTH      = 2;
    localparam int RES_DEPTH      = 2;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_STR   = 2'd0;
    localparam t_kind KIND_DIGIT = 2'd1;
    localparam t_kind KIND_EMPTY = 2'd2;

    typedef struct packed {
        t_kind             kind;
        logic [ELEM_W-1:0] element;
        logic              negative;
        logic              last;
    } t_item;

endpackage

>>> rtl/core/legacy_object_hash.sv
// Top level of the legacy object hash block: front stage, item queue,
// back stage and result queue. Depends on lohash_pkg and the lohash_* modules.
//
// Usage: the elements of one object enter on the input queue port: an item
// is taken at a clock edge with push high and full low. The item marked last
// (or an empty request, which stands for an empty string or a zero integer
// and gives 0) produces one result, the hash of the whole object.
// Results leave through the output queue port: o_hash_value is valid while
// empty is low, and the item is removed at an edge with pop high.
// The last element passes the front register, the item queue, the finishing
// register and the result queue. Throughput, unless the receiver stalls: one
// element per cycle, set by the back stage, folding each into the accumulator.
// When the receiver stalls, the result queue fills, then the back stage
// holds, then the item queue and the front stage fill and full rises.
// Reset clears all queues and returns the accumulator, count and
// first-element flag to their idle state; no object is in progress.
module legacy_object_hash #(
    parameter int WORD_BITS  = lohash_pkg::WORD_BITS_DEF,
    parameter int DIGIT_BITS = lohash_pkg::DIGIT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_func,
    input  logic [lohash_pkg::ELEM_W-1:0]       i_element,
    input  logic                                i_negative,
    input  logic                                i_last,
    input  logic                                i_empty_req,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [lohash_pkg::OUT_W-1:0] o_hash_value
);

    logic                 w_mid_push;
    logic                 w_mid_full;
    logic                 w_mid_empty;
    logic                 w_mid_pop;
    lohash_pkg::t_item    w_mid_in;
    lohash_pkg::t_item    w_mid_out;
    logic                 w_res_valid;
    logic [WORD_BITS-1:0] w_res_value;
    logic                 w_res_full;
    logic [WORD_BITS-1:0] w_head;

    lohash_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_func      (i_func),
        .i_element   (i_element),
        .i_negative  (i_negative),
        .i_last      (i_last),
        .i_empty_req (i_empty_req),
        .i_mid_full  (w_mid_full),
        .o_full      (full),
        .o_mid_push  (w_mid_push),
        .o_mid_item  (w_mid_in)
    );

    lohash_fifo #(
        .WIDTH ($bits(lohash_pkg::t_item)),
        .DEPTH (lohash_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_full  (w_mid_full),
        .o_empty (w_mid_empty)
    );

    lohash_back #(
        .WORD_BITS  (WORD_BITS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!w_mid_empty),
        .i_item      (w_mid_out),
        .i_res_ready (!w_res_full),
        .o_pop       (w_mid_pop),
        .o_res_valid (w_res_valid),
        .o_res_value (w_res_value)
    );

    lohash_fifo #(
        .WIDTH (WORD_BITS),
        .DEPTH (lohash_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res_value),
        .i_pop   (pop),
        .o_data  (w_head),
        .o_full  (w_res_full),
        .o_empty (empty)
    );

    assign o_hash_value = lohash_pkg::OUT_W'($signed(w_head));

endmodule

>>> rtl/core/lohash_fifo.sv
// Small first-in first-out queue held in flip-flops, used between the stages.
// Depends on nothing; width and depth come in as parameters.
module lohash_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/core/lohash_front.sv
// Front stage: accepts input items, classifies them and hands them to the queue.
// Depends on lohash_pkg for the item type and kind codes.
module lohash_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic                    i_func,
    input  logic [lohash_pkg::ELEM_W-1:0] i_element,
    input  logic                    i_negative,
    input  logic                    i_last,
    input  logic                    i_empty_req,
    input  logic                    i_mid_full,
    output logic                    o_full,
    output logic                    o_mid_push,
    output lohash_pkg::t_item       o_mid_item
);

    logic              r_valid, n_valid;
    lohash_pkg::t_item r_item;
    lohash_pkg::t_item w_item;
    logic              w_ready;
    logic              w_take;

    // An empty request overrides the mode of the element.
    always_comb begin
        w_item.kind     = i_empty_req ? lohash_pkg::KIND_EMPTY :
                          (i_func ? lohash_pkg::KIND_DIGIT : lohash_pkg::KIND_STR);
        w_item.element  = i_element;
        w_item.negative = i_negative;
        w_item.last     = i_last;
    end

    assign w_ready    = !r_valid || !i_mid_full;
    assign w_take     = i_push && w_ready;
    assign o_full     = !w_ready;
    assign o_mid_push = r_valid && !i_mid_full;
    assign o_mid_item = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (o_mid_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= w_item;
        end
    end

endmodule

>>> rtl/core/lohash_back.sv
// Back stage: runs the hash accumulator and the finishing step of each object.
// Depends on lohash_pkg for the item type, kind codes and hash constants.
module lohash_back #(
    parameter int WORD_BITS  = lohash_pkg::WORD_BITS_DEF,
    parameter int DIGIT_BITS = lohash_pkg::DIGIT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  lohash_pkg::t_item    i_item,
    input  logic                 i_res_ready,
    output logic                 o_pop,
    output logic                 o_res_valid,
    output logic [WORD_BITS-1:0] o_res_value
);

    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [WORD_BITS-1:0] r_cnt, n_cnt;
    logic                 r_awaiting, n_awaiting;

    logic                 r_fin_valid, n_fin_valid;
    logic [WORD_BITS-1:0] r_fin_x;
    logic [WORD_BITS-1:0] r_fin_cnt;
    lohash_pkg::t_kind    r_fin_kind;
    logic                 r_fin_neg;

    logic                 w_produces;
    logic                 w_fin_ready;
    logic                 w_load_fin;
    logic [WORD_BITS-1:0] w_elem;
    logic [WORD_BITS-1:0] w_seed_x;
    logic [WORD_BITS-1:0] w_prod;
    logic [WORD_BITS-1:0] w_str_x;
    logic [WORD_BITS-1:0] w_digit;
    logic [WORD_BITS-1:0] w_rot;
    logic [WORD_BITS:0]   w_sum;
    logic [WORD_BITS-1:0] w_dig_x;
    logic [WORD_BITS-1:0] w_next_x;
    logic [WORD_BITS-1:0] w_next_cnt;
    logic [WORD_BITS-1:0] w_fin;

    assign w_produces  = i_item.last || (i_item.kind == lohash_pkg::KIND_EMPTY);
    assign w_fin_ready = !r_fin_valid || i_res_ready;
    assign o_pop       = i_valid && (!w_produces || w_fin_ready);
    assign w_load_fin  = o_pop && w_produces;

    // String step: the first element seeds the accumulator before the multiply.
    assign w_elem   = WORD_BITS'(i_item.element);
    assign w_seed_x = r_awaiting ? (w_elem << lohash_pkg::SEED_SHIFT) : r_acc;

    // The constant multiply reduces to one shifted copy per set bit.
    always_comb begin
        w_prod = '0;
        for (int k = 0; k < lohash_pkg::MULT_W; k++) begin
            if (lohash_pkg::MULTIPLIER[k]) begin
                w_prod = w_prod + (w_seed_x << k);
            end
        end
    end
    assign w_str_x = w_prod ^ w_elem;

    // Digit step: rotate, then add with the carry folded back into bit zero.
    assign w_digit = WORD_BITS'(i_item.element[DIGIT_BITS-1:0]);
    assign w_rot   = {r_acc[WORD_BITS-DIGIT_BITS-1:0], r_acc[WORD_BITS-1:WORD_BITS-DIGIT_BITS]};
    assign w_sum   = {1'b0, w_rot} + {1'b0, w_digit};
    assign w_dig_x = w_sum[WORD_BITS-1:0] + WORD_BITS'(w_sum[WORD_BITS]);

    assign w_next_x   = (i_item.kind == lohash_pkg::KIND_DIGIT) ? w_dig_x : w_str_x;
    assign w_next_cnt = r_cnt + 1'b1;

    always_comb begin
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_awaiting = r_awaiting;
        if (o_pop) begin
            if (w_produces) begin
                n_acc      = '0;
                n_cnt      = '0;
                n_awaiting = 1'b1;
            end else begin
                n_acc      = w_next_x;
                n_cnt      = w_next_cnt;
                n_awaiting = 1'b0;
            end
        end
    end

    always_comb begin
        n_fin_valid = r_fin_valid;
        if (w_load_fin) begin
            n_fin_valid = 1'b1;
        end else if (i_res_ready) begin
            n_fin_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_awaiting  <= 1'b1;
            r_fin_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_awaiting  <= n_awaiting;
            r_fin_valid <= n_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_fin) begin
            r_fin_x    <= w_next_x;
            r_fin_cnt  <= w_next_cnt;
            r_fin_kind <= i_item.kind;
            r_fin_neg  <= i_item.negative;
        end
    end

    // Finishing step; an all-ones word would read as -1 and becomes -2.
    always_comb begin
        unique case (r_fin_kind)
            lohash_pkg::KIND_STR:   w_fin = r_fin_x ^ r_fin_cnt;
            lohash_pkg::KIND_DIGIT: w_fin = r_fin_neg ? ('0 - r_fin_x) : r_fin_x;
            default:                w_fin = '0;
        endcase
        o_res_value = (&w_fin) ? ~WORD_BITS'(1) : w_fin;
    end

    assign o_res_valid = r_fin_valid;

endmodule

>>> tb/sv/hash_checker.sv
// Checker for the legacy object hash block: watches both queue ports,
// predicts each object's hash and compares it with what the block returns.
// Depends on lohash_pkg for field widths and the hash constants.
module hash_checker #(
    parameter int WORD_BITS  = lohash_pkg::WORD_BITS_DEF,
    parameter int DIGIT_BITS = lohash_pkg::DIGIT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_full,
    input  logic                                i_func,
    input  logic [lohash_pkg::ELEM_W-1:0]       i_element,
    input  logic                                i_negative,
    input  logic                                i_last,
    input  logic                                i_empty_req,
    input  logic                                i_empty,
    input  logic                                i_pop,
    input  logic signed [lohash_pkg::OUT_W-1:0] i_hash_value,
    output int                                  o_fail_count,
    output int                                  o_waiting,
    output int                                  o_checked
);

    localparam logic [63:0] WORD_MASK  = {64{1'b1}} >> (64 - WORD_BITS);
    localparam logic [63:0] DIGIT_MASK = (64'd1 << DIGIT_BITS) - 64'd1;

    logic [63:0]                         hash_acc     = '0;
    logic [63:0]                         obj_len      = '0;
    bit                                  seed_pending = 1'b1;
    logic signed [lohash_pkg::OUT_W-1:0] expected_hashes[$];
    int                                  fail_count   = 0;
    int                                  checked      = 0;

    function automatic void start_object();
        hash_acc     = '0;
        obj_len      = '0;
        seed_pending = 1'b1;
    endfunction

    // Folds one accepted item into the running hash; a closing item queues
    // the finished hash of the object.
    function automatic void absorb_item(input logic f,
                                        input logic [lohash_pkg::ELEM_W-1:0] el,
                                        input logic neg, input logic lst,
                                        input logic emp);
        logic [63:0] x;
        logic [63:0] d;
        if (emp) begin
            start_object();
            expected_hashes.push_back('0);
            return;
        end
        x = hash_acc & WORD_MASK;
        d = 64'(el);
        if (!f) begin
            if (seed_pending)
                x = (d << lohash_pkg::SEED_SHIFT) & WORD_MASK;
            x = ((x * 64'(lohash_pkg::MULTIPLIER)) ^ d) & WORD_MASK;
        end else begin
            d = d & DIGIT_MASK;
            x = ((x >> (WORD_BITS - DIGIT_BITS)) | (x << DIGIT_BITS)) & WORD_MASK;
            x = (x + d) & WORD_MASK;
            // A wrapped sum is smaller than the addend: the carry goes back in.
            if (x < d)
                x = (x + 64'd1) & WORD_MASK;
        end
        hash_acc     = x;
        obj_len      = obj_len + 64'd1;
        seed_pending = 1'b0;
        if (!lst)
            return;
        if (!f)
            x = (x ^ obj_len) & WORD_MASK;
        else if (neg)
            x = (64'd0 - x) & WORD_MASK;
        // Minus one is reserved as an error code, so it is replaced by minus two.
        if (x == WORD_MASK)
            x = (WORD_MASK - 64'd1) & WORD_MASK;
        if (WORD_BITS < 64 && x[WORD_BITS-1])
            x = x | ~WORD_MASK;
        expected_hashes.push_back(x);
        start_object();
    endfunction

    always @(posedge i_clk) begin
        logic signed [lohash_pkg::OUT_W-1:0] want;
        if (i_rst_n) begin
            if (i_pop && !i_empty) begin
                if (expected_hashes.size() == 0) begin
                    if (fail_count < 10)
                        $display("[%0t] hash %h returned with no object pending",
                                 $time, i_hash_value);
                    fail_count++;
                end else begin
                    want = expected_hashes.pop_front();
                    checked++;
                    if (i_hash_value !== want) begin
                        if (fail_count < 10)
                            $display("[%0t] hash_value mismatch: expected %h, got %h",
                                     $time, want, i_hash_value);
                        fail_count++;
                    end
                end
            end
            if (i_push && !i_full)
                absorb_item(i_func, i_element, i_negative, i_last, i_empty_req);
        end
        o_fail_count <= fail_count;
        o_waiting    <= expected_hashes.size();
        o_checked    <= checked;
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the legacy object hash testbench: clock, reset, item stimulus
// and result draining. Depends on lohash_pkg, legacy_object_hash and hash_checker.
module tb_top;

    localparam int RANDOM_ITEMS = 650;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                push;
    logic                                full;
    logic                                i_func;
    logic [lohash_pkg::ELEM_W-1:0]       i_element;
    logic                                i_negative;
    logic                                i_last;
    logic                                i_empty_req;
    logic                                empty;
    logic                                pop;
    logic signed [lohash_pkg::OUT_W-1:0] o_hash_value;

    int fail_count;
    int n_waiting;
    int n_checked;

    int  items_sent;
    int  n_str_obj;
    int  n_int_obj;
    int  n_empty;
    int  n_odd;
    bit  calm;

    legacy_object_hash DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_func       (i_func),
        .i_element    (i_element),
        .i_negative   (i_negative),
        .i_last       (i_last),
        .i_empty_req  (i_empty_req),
        .empty        (empty),
        .pop          (pop),
        .o_hash_value (o_hash_value)
    );

    hash_checker u_hash_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_func       (i_func),
        .i_element    (i_element),
        .i_negative   (i_negative),
        .i_last       (i_last),
        .i_empty_req  (i_empty_req),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_hash_value (o_hash_value),
        .o_fail_count (fail_count),
        .o_waiting    (n_waiting),
        .o_checked    (n_checked)
    );

    always #5 i_clk = ~i_clk;

    // Mostly no gap, some short ones and now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Bytes mostly, then code units, full-width, extremes; digits mostly full-width.
    function automatic logic [lohash_pkg::ELEM_W-1:0] pick_element(input logic f);
        int r;
        r = $urandom_range(0, 99);
        if (f) begin
            if (r < 80)
                return lohash_pkg::ELEM_W'($urandom());
        end else begin
            if (r < 60)
                return lohash_pkg::ELEM_W'($urandom_range(0, 255));
            if (r < 85)
                return lohash_pkg::ELEM_W'($urandom_range(0, 65535));
            if (r < 95)
                return lohash_pkg::ELEM_W'($urandom());
        end
        return (r % 2) ? '1 : '0;
    endfunction

    task automatic send_item(input logic f, input logic [lohash_pkg::ELEM_W-1:0] el,
                             input logic neg, input logic lst, input logic emp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_func      <= f;
        i_element   <= el;
        i_negative  <= neg;
        i_last      <= lst;
        i_empty_req <= emp;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        items_sent++;
    endtask

    // The sign flag on inner elements is random; only the final one counts.
    task automatic send_object(input logic f, input int len, input logic neg);
        for (int i = 0; i < len; i++)
            send_item(f, pick_element(f), (i == len - 1) ? neg : 1'($urandom()),
                      i == len - 1, 1'b0);
        if (f)
            n_int_obj++;
        else
            n_str_obj++;
    endtask

    task automatic send_empty();
        send_item(1'($urandom()), lohash_pkg::ELEM_W'($urandom()), 1'($urandom()),
                  1'($urandom()), 1'b1);
        n_empty++;
    endtask

    task automatic run_directed();
        send_empty();
        send_item(1'b0, '0, 1'b0, 1'b1, 1'b0);
        send_item(1'b0, '1, 1'b1, 1'b1, 1'b0);
        send_item(1'b0, lohash_pkg::ELEM_W'(97), 1'b0, 1'b0, 1'b0);
        send_item(1'b0, lohash_pkg::ELEM_W'(98), 1'b0, 1'b0, 1'b0);
        send_item(1'b0, lohash_pkg::ELEM_W'(99), 1'b0, 1'b1, 1'b0);
        n_str_obj += 3;
        // Negative single digits: the largest, one (hashes to minus two) and zero.
        send_item(1'b1, '1, 1'b1, 1'b1, 1'b0);
        send_item(1'b1, lohash_pkg::ELEM_W'(1), 1'b1, 1'b1, 1'b0);
        send_item(1'b1, '0, 1'b1, 1'b1, 1'b0);
        // Three full digits force the end-around carry.
        repeat (2) send_item(1'b1, '1, 1'b0, 1'b0, 1'b0);
        send_item(1'b1, '1, 1'b0, 1'b1, 1'b0);
        // The sign flag on an inner digit must be ignored.
        send_item(1'b1, lohash_pkg::ELEM_W'(12345), 1'b1, 1'b0, 1'b0);
        send_item(1'b1, lohash_pkg::ELEM_W'(678), 1'b0, 1'b1, 1'b0);
        n_int_obj += 5;
        // An empty request in the middle of an object throws the object away.
        send_item(1'b0, lohash_pkg::ELEM_W'(120), 1'b0, 1'b0, 1'b0);
        send_empty();
        send_item(1'b0, lohash_pkg::ELEM_W'(121), 1'b0, 1'b1, 1'b0);
        // Mixed objects: a digit first is not seeded; the finish follows the last func.
        send_item(1'b1, lohash_pkg::ELEM_W'(5), 1'b0, 1'b0, 1'b0);
        send_item(1'b0, lohash_pkg::ELEM_W'(113), 1'b1, 1'b1, 1'b0);
        send_item(1'b0, lohash_pkg::ELEM_W'(122), 1'b0, 1'b0, 1'b0);
        send_item(1'b1, '1, 1'b1, 1'b1, 1'b0);
        n_str_obj++;
        n_odd += 3;
    endtask

    task automatic run_random();
        int first;
        int r;
        int len;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            calm = ((items_sent - first) / 100) % 3 == 1;
            r    = $urandom_range(0, 99);
            if (r < 8) begin
                send_empty();
            end else if (r < 13) begin
                len = $urandom_range(1, 5);
                repeat (len) begin
                    r = $urandom_range(0, 1);
                    send_item(1'(r), pick_element(1'(r)), 1'($urandom()), 1'b0, 1'b0);
                end
                send_empty();
                n_odd++;
            end else if (r < 18) begin
                len = $urandom_range(2, 6);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 1);
                    send_item(1'(r), pick_element(1'(r)), 1'($urandom()), i == len - 1, 1'b0);
                end
                n_odd++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                send_object(1'($urandom()), len, 1'($urandom()));
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop   <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_func      = 1'b0;
        i_element   = '0;
        i_negative  = 1'b0;
        i_last      = 1'b0;
        i_empty_req = 1'b0;
        items_sent  = 0;
        n_str_obj   = 0;
        n_int_obj   = 0;
        n_empty     = 0;
        n_odd       = 0;
        calm        = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        push <= 1'b0;
        @(posedge i_clk);
        while (n_waiting != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d items: %0d string objects, %0d integer objects, %0d empty requests,",
                 items_sent, n_str_obj, n_int_obj, n_empty);
        $display("%0d mixed or aborted objects; %0d hashes compared, %0d errors.",
                 n_odd, n_checked, fail_count);
        if (fail_count == 0 && n_waiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule
